[hdl/ybf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ybf_pkg
// shared types, codes and the crc step of the ymodem block framer
// ----------------------------------------------------------------------------
package ybf_pkg;

    localparam logic [1:0] OP_PAYLOAD = 2'd0;
    localparam logic [1:0] OP_FILL    = 2'd1;
    localparam logic [1:0] OP_EOT     = 2'd2;

    localparam logic [7:0] CH_SOH      = 8'h01;
    localparam logic [7:0] CH_STX      = 8'h02;
    localparam logic [7:0] CH_EOT      = 8'h04;
    localparam logic [7:0] CH_SUB      = 8'h1A;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_ALL_ONES = 8'hFF;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'h0000;
    localparam logic [7:0]  BLK_FIRST = 8'h01;

    localparam int COUNT_W     = 11;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       small_block;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       block_done;
    } t_out_item;

    // one accepted item, as the back end has to emit it
    typedef struct packed {
        logic        eot;
        logic        hdr;
        logic        hdr_small;
        logic [7:0]  blk_num;
        logic [7:0]  data;
        logic        crc_tail;
        logic [15:0] crc;
    } t_run;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[hdl/ybf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ybf_front
// accepts input items, tracks block state and crc, queues one run per payload, fill or end item
// ----------------------------------------------------------------------------
module ybf_front #(
    parameter int LARGE_BLOCK_BYTES = 1024,
    parameter int SMALL_BLOCK_BYTES = 128
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  ybf_pkg::t_in_item  i_in_item,
    input  wire                i_full,
    output logic               o_push,
    output ybf_pkg::t_run      o_run
);
    import ybf_pkg::*;

    localparam logic [COUNT_W-1:0] LargeSize = COUNT_W'(LARGE_BLOCK_BYTES);
    localparam logic [COUNT_W-1:0] SmallSize = COUNT_W'(SMALL_BLOCK_BYTES);

    logic               r_in_block, n_in_block;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_is_small, n_is_small;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_blk, n_blk;

    logic               accept;
    logic               cur_small;
    logic [7:0]         cur_byte;
    logic [15:0]        crc_new;
    logic [COUNT_W-1:0] cnt_new;
    t_run               run;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        n_in_block = r_in_block;
        n_count    = r_count;
        n_is_small = r_is_small;
        n_crc      = r_crc;
        n_blk      = r_blk;
        run        = '0;
        o_push     = 1'b0;
        cur_small  = r_in_block ? r_is_small : i_in_item.small_block;
        if (i_in_item.operation == OP_PAYLOAD) begin
            cur_byte = i_in_item.data_byte;
        end else begin
            cur_byte = cur_small ? CH_NUL : CH_SUB;
        end
        crc_new = crc16_byte(r_in_block ? r_crc : CRC_INIT, cur_byte);
        cnt_new = (r_in_block ? r_count : '0) + COUNT_W'(1);
        if (accept) begin
            case (i_in_item.operation) inside
                OP_EOT: begin
                    o_push     = 1'b1;
                    run.eot    = 1'b1;
                    n_in_block = 1'b0;
                    n_count    = '0;
                    n_crc      = CRC_INIT;
                    n_blk      = BLK_FIRST;
                end
                OP_PAYLOAD, OP_FILL: begin
                    o_push        = 1'b1;
                    run.hdr       = !r_in_block;
                    run.hdr_small = cur_small;
                    run.blk_num   = r_blk;
                    run.data      = cur_byte;
                    run.crc       = crc_new;
                    if (cnt_new >= (cur_small ? SmallSize : LargeSize)) begin
                        run.crc_tail = 1'b1;
                        n_in_block   = 1'b0;
                        n_count      = '0;
                        n_crc        = CRC_INIT;
                        if (!cur_small) begin
                            n_blk = r_blk + 8'd1;
                        end
                    end else begin
                        n_in_block = 1'b1;
                        n_is_small = cur_small;
                        n_count    = cnt_new;
                        n_crc      = crc_new;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_run = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_block <= 1'b0;
            r_count    <= '0;
            r_is_small <= 1'b0;
            r_crc      <= CRC_INIT;
            r_blk      <= BLK_FIRST;
        end else begin
            r_in_block <= n_in_block;
            r_count    <= n_count;
            r_is_small <= n_is_small;
            r_crc      <= n_crc;
            r_blk      <= n_blk;
        end
    end

endmodule
`default_nettype wire

[hdl/ybf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ybf_queue
// short run queue between front and back ends
// ----------------------------------------------------------------------------
module ybf_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  ybf_pkg::t_run  i_run,
    input  wire            i_pop,
    output ybf_pkg::t_run  o_head,
    output logic           o_full,
    output logic           o_empty
);
    import ybf_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_run            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == CntW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PtrW'(1);
            end
            r_cnt <= r_cnt + CntW'(i_push) - CntW'(i_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[hdl/ybf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ybf_back
// walks each queued run and emits its bytes into the output register
// ----------------------------------------------------------------------------
module ybf_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  ybf_pkg::t_run      i_head,
    input  wire                i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output ybf_pkg::t_out_item o_out_item
);
    import ybf_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_HDR2, PH_DATA, PH_CRCH, PH_CRCL, PH_EOT
    } t_phase;

    logic      r_mid;
    t_phase    r_phase;
    logic      r_ov;
    t_out_item r_out;

    t_phase    cur, nxt;
    logic      load, fin;
    t_out_item item;

    assign load = (!r_ov || !i_out_stall) && !i_empty;

    always_comb begin
        if (r_mid) begin
            cur = r_phase;
        end else if (i_head.eot) begin
            cur = PH_EOT;
        end else if (i_head.hdr) begin
            cur = PH_HDR0;
        end else begin
            cur = PH_DATA;
        end
        item = '0;
        fin  = 1'b0;
        nxt  = PH_DATA;
        case (cur)
            PH_HDR0: begin
                item.out_byte = i_head.hdr_small ? CH_SOH : CH_STX;
                nxt = PH_HDR1;
            end
            PH_HDR1: begin
                item.out_byte = i_head.hdr_small ? CH_NUL : i_head.blk_num;
                nxt = PH_HDR2;
            end
            PH_HDR2: begin
                item.out_byte = i_head.hdr_small ? CH_ALL_ONES : ~i_head.blk_num;
                nxt = PH_DATA;
            end
            PH_DATA: begin
                item.out_byte = i_head.data;
                fin = !i_head.crc_tail;
                nxt = PH_CRCH;
            end
            PH_CRCH: begin
                item.out_byte = i_head.crc[15:8];
                nxt = PH_CRCL;
            end
            PH_CRCL: begin
                item.out_byte   = i_head.crc[7:0];
                item.block_done = 1'b1;
                fin = 1'b1;
            end
            PH_EOT: begin
                item.out_byte = CH_EOT;
                fin = 1'b1;
            end
            default: begin
                fin = 1'b1;
            end
        endcase
        item.last_of_run = fin;
    end

    assign o_pop       = load && fin;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_phase <= PH_DATA;
            r_ov    <= 1'b0;
        end else begin
            if (load) begin
                r_ov    <= 1'b1;
                r_out   <= item;
                r_mid   <= !fin;
                r_phase <= nxt;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.block_done) |-> r_out.last_of_run)
        else $error("block end byte not last of its run");
    a_mid_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> !i_empty)
        else $error("run in progress without queued head");
    a_crc_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && cur == PH_CRCH) |=> (r_mid && r_phase == PH_CRCL))
        else $error("crc high byte not followed by low byte");
`endif

endmodule
`default_nettype wire

[hdl/ymodem_block_framer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ymodem_block_framer_top
// frames payload, fill and end items into a ymodem byte stream with crc-16
// ----------------------------------------------------------------------------
// input channel carries one item per word: payload byte, fill byte or end.
// output channel carries one framed byte per word, flagged last of its run
// and block done on the crc low byte that closes a block.
// a block opens with three header bytes (soh 00 ff or stx n ~n), passes its
// data bytes, and closes with the crc high then low byte; end gives eot.
// an accepted item is queued, and its first byte then enters the output word.
// payload and fill items are taken one per cycle while the queue has room;
// the output side emits one byte per cycle unless stalled, so a block of n
// bytes becomes n + 5 output bytes and the run queue between the tracking
// front end and the serializer absorbs the header and crc bytes. unused
// operation codes are taken and dropped. when the receiver stalls the output
// word holds and the queue fills; once it holds four runs the input stalls.
// reset closes any open block, clears the crc and byte count, empties the
// queue and restarts block numbering at 1.
// ----------------------------------------------------------------------------
module ymodem_block_framer_top #(
    parameter int LARGE_BLOCK_BYTES = 1024,
    parameter int SMALL_BLOCK_BYTES = 128
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  ybf_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output ybf_pkg::t_out_item o_out_item
);
    import ybf_pkg::*;

    logic push, pop, full, empty;
    t_run run, head;

    ybf_front #(
        .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES),
        .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_full     (full),
        .o_push     (push),
        .o_run      (run)
    );

    ybf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    ybf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
